FILE: hdl/rfr_pkg.sv
// shared types, constants and header classifier for the rdss frame receiver
`default_nettype none

package rfr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;
  localparam int KIND_W = 4;
  localparam int STAT_W = 2;
  localparam int HDR_W  = 32;

  localparam logic [BYTE_W-1:0] START_BYTE    = 8'h24;
  localparam logic [LEN_W-1:0]  MIN_FRAME_LEN = 16'd8;

  // frame_kind codes
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 4'd10;
  localparam int                NUM_KINDS    = 10;

  // frame_status codes
  localparam logic [STAT_W-1:0] STAT_GOOD     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISMATCH = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_LEN  = 2'd2;

  typedef logic [HDR_W-1:0] hdr_word_t;

  // header bytes 1..4 of each known class, first byte on top
  localparam hdr_word_t KIND_WORDS [NUM_KINDS] = '{
    32'h5369675F,  // Sig_
    32'h506F735F,  // Pos_
    32'h4D73675F,  // Msg_
    32'h4273745F,  // Bst_
    32'h4963635F,  // Icc_
    32'h5374735F,  // Sts_
    32'h5A73745F,  // Zst_
    32'h5A72645F,  // Zrd_
    32'h54696D5F,  // Tim_
    32'h46626B5F   // Fbk_
  };

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
  } result_t;

  // parallel compare against the known headers
  function automatic logic [KIND_W-1:0] classify(input hdr_word_t word);
    logic [KIND_W-1:0] kind;
    kind = KIND_UNKNOWN;
    for (int i = NUM_KINDS - 1; i >= 0; i--) begin
      if (KIND_WORDS[i] == word) begin
        kind = KIND_W'(i);
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rfr_in_stage.sv
// input register stage holding one received byte
`default_nettype none

module rfr_in_stage (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [rfr_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic                     advance,
  output logic                          s1_valid,
  output logic [rfr_pkg::BYTE_W-1:0]    s1_byte
);

  logic take;
  logic s1_valid_next;

  assign in_ready = !s1_valid || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    s1_valid_next = s1_valid;
    if (take) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rfr_framer.sv
// framing state, running checksum and result decision for one byte
`default_nettype none

module rfr_framer #(
  parameter int MAX_FRAME_LEN = 2048
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       advance,
  input  wire logic [rfr_pkg::BYTE_W-1:0] s1_byte,
  output logic                            res_valid,
  output rfr_pkg::result_t                res
);

  localparam int CNT_W = $clog2(MAX_FRAME_LEN);
  localparam int CMP_W = rfr_pkg::LEN_W + 1;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_FRAME_LEN);

  logic                       in_frame, in_frame_next;
  logic [CNT_W-1:0]           byte_count, byte_count_next;
  logic [rfr_pkg::BYTE_W-1:0] running_xor, running_xor_next;
  logic [rfr_pkg::LEN_W-1:0]  expected_length, expected_length_next;
  rfr_pkg::hdr_word_t         header_word, header_word_next;

  logic [rfr_pkg::LEN_W-1:0]  len_full;
  logic                       last_byte;
  logic                       bad_len;

  assign len_full  = {expected_length[rfr_pkg::LEN_W-1:rfr_pkg::BYTE_W], s1_byte};
  assign last_byte = (byte_count >= CNT_W'(7)) &&
                     ((CMP_W'(byte_count) + CMP_W'(1)) == {1'b0, expected_length});
  assign bad_len   = (len_full < rfr_pkg::MIN_FRAME_LEN) || ({1'b0, len_full} > MAX_LEN);

  always_comb begin
    in_frame_next        = in_frame;
    byte_count_next      = byte_count;
    running_xor_next     = running_xor;
    expected_length_next = expected_length;
    header_word_next     = header_word;
    res_valid            = 1'b0;
    res.kind             = rfr_pkg::classify(header_word);
    res.status           = rfr_pkg::STAT_GOOD;
    res.length           = expected_length;

    if (!in_frame) begin
      if (s1_byte == rfr_pkg::START_BYTE) begin
        in_frame_next        = 1'b1;
        byte_count_next      = CNT_W'(1);
        running_xor_next     = s1_byte;
        expected_length_next = '0;
        header_word_next     = '0;
      end
    end else if (last_byte) begin
      res_valid  = 1'b1;
      res.status = (s1_byte == running_xor) ? rfr_pkg::STAT_GOOD : rfr_pkg::STAT_MISMATCH;
    end else begin
      running_xor_next = running_xor ^ s1_byte;
      byte_count_next  = byte_count + CNT_W'(1);
      if (byte_count <= CNT_W'(4)) begin
        header_word_next = {header_word[rfr_pkg::HDR_W-rfr_pkg::BYTE_W-1:0], s1_byte};
      end else if (byte_count == CNT_W'(5)) begin
        expected_length_next = {s1_byte, {rfr_pkg::BYTE_W{1'b0}}};
      end else if (byte_count == CNT_W'(6)) begin
        expected_length_next = len_full;
        if (bad_len) begin
          res_valid  = 1'b1;
          res.status = rfr_pkg::STAT_BAD_LEN;
          res.length = len_full;
        end
      end
    end

    // any result sends the framer back to hunting
    if (res_valid) begin
      in_frame_next        = 1'b0;
      byte_count_next      = '0;
      running_xor_next     = '0;
      expected_length_next = '0;
      header_word_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      byte_count      <= '0;
      running_xor     <= '0;
      expected_length <= '0;
      header_word     <= '0;
    end else if (advance) begin
      in_frame        <= in_frame_next;
      byte_count      <= byte_count_next;
      running_xor     <= running_xor_next;
      expected_length <= expected_length_next;
      header_word     <= header_word_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rfr_out_stage.sv
// result register that holds a finished frame report until taken
`default_nettype none

module rfr_out_stage (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       load,
  input  wire rfr_pkg::result_t           res,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rfr_pkg::KIND_W-1:0]      frame_kind,
  output logic [rfr_pkg::STAT_W-1:0]      frame_status,
  output logic [rfr_pkg::LEN_W-1:0]       frame_length
);

  rfr_pkg::result_t held;
  logic             out_valid_next;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign frame_kind   = held.kind;
  assign frame_status = held.status;
  assign frame_length = held.length;

endmodule

`default_nettype wire

FILE: hdl/rdss_frame_receiver.sv
// top level of the rdss serial frame receiver
// path: an accepted byte is held in the byte register and framed when it advances; a report it
//   closes is loaded into the report register, which raises out_valid
// throughput: one byte per cycle; a byte waits only while an untaken report is held
// reset: synchronous rst clears the input and result valid flags and returns the
//   framer to hunting for a start byte, with count, checksum, length and header at zero
`default_nettype none

module rdss_frame_receiver #(
  parameter int MAX_FRAME_LEN = 2048
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // received byte channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [rfr_pkg::BYTE_W-1:0] rx_byte,
  // frame report channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rfr_pkg::KIND_W-1:0]      frame_kind,
  output logic [rfr_pkg::STAT_W-1:0]      frame_status,
  output logic [rfr_pkg::LEN_W-1:0]       frame_length
);

  logic                       s1_valid;
  logic [rfr_pkg::BYTE_W-1:0] s1_byte;
  logic                       advance;
  logic                       res_valid;
  rfr_pkg::result_t           res;

  // the held byte moves through the framer whenever the result register is free
  // or being emptied this cycle, so a report never overwrites an untaken one
  assign advance = s1_valid && (!out_valid || out_ready);

  // byte register: takes a new transaction while the previous byte is framed
  rfr_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  // hunting / counting / xor, decides when a report goes out
  rfr_framer #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_framer (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .s1_byte   (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // report register
  rfr_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && res_valid),
    .res          (res),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_kind   (frame_kind),
    .frame_status (frame_status),
    .frame_length (frame_length)
  );

endmodule

`default_nettype wire

FILE: hdl/rfr_checker.sv
// port-level checks for the rdss frame receiver and their bind
`default_nettype none

module rfr_checker #(
  parameter int MAX_FRAME_LEN = 2048
) (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [rfr_pkg::KIND_W-1:0] frame_kind,
  input wire logic [rfr_pkg::STAT_W-1:0] frame_status,
  input wire logic [rfr_pkg::LEN_W-1:0]  frame_length
);

  localparam logic [rfr_pkg::LEN_W:0] MAX_LEN = (rfr_pkg::LEN_W + 1)'(MAX_FRAME_LEN);

  // a stalled report holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_kind) &&
      $stable(frame_status) && $stable(frame_length))
    else $error("report changed while stalled");

  // reset leaves no report pending
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("report pending after reset");

  // a length fault is only reported for a length outside the legal range
  a_bad_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == rfr_pkg::STAT_BAD_LEN |->
      frame_length < rfr_pkg::MIN_FRAME_LEN || {1'b0, frame_length} > MAX_LEN)
    else $error("length fault on a legal length");

  // a completed frame always has a legal length
  a_good_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status != rfr_pkg::STAT_BAD_LEN |->
      frame_length >= rfr_pkg::MIN_FRAME_LEN && {1'b0, frame_length} <= MAX_LEN)
    else $error("completed frame with illegal length");

  // status and kind codes stay in their defined range
  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_kind <= rfr_pkg::KIND_UNKNOWN &&
      (frame_status == rfr_pkg::STAT_GOOD || frame_status == rfr_pkg::STAT_MISMATCH ||
       frame_status == rfr_pkg::STAT_BAD_LEN))
    else $error("undefined report code");

endmodule

bind rdss_frame_receiver rfr_checker #(
  .MAX_FRAME_LEN (MAX_FRAME_LEN)
) u_rfr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .frame_kind   (frame_kind),
  .frame_status (frame_status),
  .frame_length (frame_length)
);

`default_nettype wire

FILE: sim/rdss_frame_check_pkg.sv
// frame report scoreboard: predicts rdss frame reports from received bytes and checks them
`timescale 1ns / 100ps

package rdss_frame_check_pkg;

  import rfr_pkg::*;

  class frame_scoreboard;
    int unsigned       max_len;
    int unsigned       mismatches;
    result_t           expected_reports[$];

    // framer state as the block should hold it
    logic              framing;
    logic [10:0]       taken;
    logic [BYTE_W-1:0] xor_acc;
    logic [LEN_W-1:0]  len_field;
    hdr_word_t         header;

    function new(int unsigned max_len);
      this.max_len = max_len;
      mismatches   = 0;
      start_hunt();
    endfunction

    function void start_hunt();
      framing   = 1'b0;
      taken     = '0;
      xor_acc   = '0;
      len_field = '0;
      header    = '0;
    endfunction

    function logic [KIND_W-1:0] kind_of(hdr_word_t word);
      for (int k = 0; k < NUM_KINDS; k++) begin
        if (KIND_WORDS[k] == word) begin
          return KIND_W'(k);
        end
      end
      return KIND_UNKNOWN;
    endfunction

    function void close_frame(logic [STAT_W-1:0] status);
      result_t rep;
      rep.kind   = kind_of(header);
      rep.status = status;
      rep.length = len_field;
      expected_reports.push_back(rep);
      start_hunt();
    endfunction

    // one accepted byte transaction
    function void note_byte(logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] next_count;
      if (!framing) begin
        if (b == START_BYTE) begin
          start_hunt();
          framing = 1'b1;
          taken   = 11'd1;
          xor_acc = b;
        end
        return;
      end
      next_count = LEN_W'(taken) + 16'd1;
      if (taken >= 11'd7 && next_count == len_field) begin
        close_frame((b == xor_acc) ? STAT_GOOD : STAT_MISMATCH);
        return;
      end
      case (taken)
        11'd1, 11'd2, 11'd3, 11'd4: header = {header[HDR_W-9:0], b};
        11'd5: len_field = {b, 8'h00};
        11'd6: begin
          len_field[7:0] = b;
          if (len_field < MIN_FRAME_LEN || len_field > max_len) begin
            close_frame(STAT_BAD_LEN);
            return;
          end
        end
        default: ;
      endcase
      xor_acc = xor_acc ^ b;
      taken   = taken + 11'd1;
    endfunction

    // one accepted report transaction
    function void check_report(logic [KIND_W-1:0] kind, logic [STAT_W-1:0] status,
                               logic [LEN_W-1:0] length);
      result_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected report: kind %0d status %0d length %0d",
                   kind, status, length);
        end
        return;
      end
      want = expected_reports.pop_front();
      if (want.kind !== kind || want.status !== status || want.length !== length) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("report mismatch: expected kind %0d status %0d length %0d",
                   want.kind, want.status, want.length);
          $display("                 got      kind %0d status %0d length %0d",
                   kind, status, length);
        end
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

endpackage

FILE: sim/rdss_frame_receiver_test.sv
// self-checking testbench for the rdss frame receiver
`timescale 1ns / 100ps

module rdss_frame_receiver_test;

  import rfr_pkg::*;
  import rdss_frame_check_pkg::*;

  localparam int MAX_LEN         = 2048;
  localparam int QUIET_LIMIT     = 1000;  // cycles with no transaction on either side
  localparam int BYTES_PER_PHASE = 220;
  localparam int NUM_PHASES      = 4;

  // idling per phase: none, sender only, receiver only, both
  localparam int SEND_IDLE [NUM_PHASES]  = '{0, 47, 0, 19};
  localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 47, 19};

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] rx_byte   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [KIND_W-1:0] frame_kind;
  logic [STAT_W-1:0] frame_status;
  logic [LEN_W-1:0]  frame_length;

  int send_idle_pct    = 0;
  int recv_stall_pct   = 0;
  int quiet_cycles     = 0;
  int frame_bytes_sent = 0;

  frame_scoreboard reports = new(MAX_LEN);

  rdss_frame_receiver #(
    .MAX_FRAME_LEN(MAX_LEN)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_kind  (frame_kind),
    .frame_status(frame_status),
    .frame_length(frame_length)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // report side: random back-pressure at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: values seen here are the ones settled before the edge
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        reports.check_report(frame_kind, frame_status, frame_length);
      end
      if (in_valid && in_ready) begin
        reports.note_byte(rx_byte);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // watchdog: the block has hung on one side or the other
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // one byte transaction, with random idle cycles ahead of it
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // a frame with header, big-endian length, payload and trailing xor;
  // an out-of-range length stops after the length bytes, keep > 0 cuts the frame short,
  // fill >= 0 puts that byte in every payload position
  task automatic send_frame(input hdr_word_t hdr, input logic [LEN_W-1:0] len,
                            input bit good_sum, input int keep, input int fill = -1);
    logic [BYTE_W-1:0] frame_bytes[$];
    logic [BYTE_W-1:0] sum;
    int                total;
    frame_bytes.push_back(START_BYTE);
    frame_bytes.push_back(hdr[31:24]);
    frame_bytes.push_back(hdr[23:16]);
    frame_bytes.push_back(hdr[15:8]);
    frame_bytes.push_back(hdr[7:0]);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[7:0]);
    if (len >= MIN_FRAME_LEN && len <= MAX_LEN) begin
      repeat (int'(len) - 8) begin
        frame_bytes.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
      end
      sum = '0;
      foreach (frame_bytes[i]) sum = sum ^ frame_bytes[i];
      if (!good_sum) begin
        sum = sum ^ 8'($urandom_range(255, 1));
      end
      frame_bytes.push_back(sum);
    end
    total = (keep > 0 && keep < frame_bytes.size()) ? keep : frame_bytes.size();
    for (int i = 0; i < total; i++) begin
      send_byte(frame_bytes[i]);
    end
    frame_bytes_sent += total;
  endtask

  // mostly well-formed frames; some line noise, stray starts, cut frames and bad lengths
  task automatic send_random_frame();
    hdr_word_t         hdr;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] noise;
    int                pick;
    int                bitpos;
    int                keep;
    if ($urandom_range(99) < 25) begin
      repeat ($urandom_range(4, 1)) begin
        do noise = 8'($urandom_range(255)); while (noise == START_BYTE);
        send_byte(noise);
      end
    end
    // a lone start byte swallows the next frame as data
    if ($urandom_range(99) < 3) begin
      send_byte(START_BYTE);
    end
    hdr  = KIND_WORDS[$urandom_range(NUM_KINDS - 1)];
    pick = $urandom_range(99);
    if (pick < 15) begin
      bitpos      = $urandom_range(HDR_W - 1);
      hdr[bitpos] = ~hdr[bitpos];
    end else if (pick < 25) begin
      hdr = $urandom;
    end
    pick = $urandom_range(99);
    if (pick < 4) begin
      len = LEN_W'($urandom_range(7));
    end else if (pick < 8) begin
      len = LEN_W'($urandom_range(65535, MAX_LEN + 1));
    end else if (pick < 10) begin
      len = LEN_W'($urandom_range(255, 41));
    end else begin
      len = LEN_W'($urandom_range(40, 8));
    end
    keep = ($urandom_range(99) < 5) ? $urandom_range(6, 1) : 0;
    send_frame(hdr, len, ($urandom_range(99) < 75), keep);
  endtask

  // hold the sender off until every predicted report has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int phase_start;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: noise while hunting, including the byte values around the start byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h23);
    send_byte(8'h25);
    // every known header in a shortest frame
    for (int k = 0; k < NUM_KINDS; k++) begin
      send_frame(KIND_WORDS[k], MIN_FRAME_LEN, 1'b1, 0);
    end
    // unknown header, still checksummed
    send_frame(32'h41424344, 16'd9, 1'b1, 0);
    // checksum mismatch
    send_frame(KIND_WORDS[1], MIN_FRAME_LEN, 1'b0, 0);
    // lengths out of range on both sides
    send_frame(KIND_WORDS[2], 16'd0, 1'b1, 0);
    send_frame(KIND_WORDS[3], 16'd7, 1'b1, 0);
    send_frame(KIND_WORDS[4], 16'(MAX_LEN + 1), 1'b1, 0);
    send_frame(32'hFFFFFFFF, 16'hFFFF, 1'b1, 0);
    // start bytes inside a frame are plain data
    send_frame(KIND_WORDS[5], 16'd12, 1'b1, 0, START_BYTE);
    // a frame past 255 bytes, so both length bytes count
    send_frame(KIND_WORDS[9], 16'd300, 1'b1, 0);
    drain();

    // random traffic under each idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      phase_start    = frame_bytes_sent;
      while (frame_bytes_sent - phase_start < BYTES_PER_PHASE) begin
        send_random_frame();
      end
      drain();
    end

    // let any stray report show up before the verdict
    repeat (8) @(posedge clk);
    if (reports.mismatches == 0 && reports.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
